[design/sound_slot_cache_assert.svh]
// Assertion macros used by the sound slot cache datapath
`ifndef SOUND_SLOT_CACHE_ASSERT_SVH
`define SOUND_SLOT_CACHE_ASSERT_SVH

// property must hold at every clock edge outside reset
`define SSC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition must never be seen at a clock edge outside reset
`define SSC_ASSERT_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

[design/ssc_pkg.sv]
// Shared types and constants of the sound slot cache
`default_nettype none

package ssc_pkg;

    localparam int SLOT_COUNT_DEF = 20;
    localparam int SLOT_BASE_DEF  = 1;

    localparam int ACT_W  = 3;
    localparam int NUM_W  = 16;
    localparam int FADE_W = 16;
    localparam int SLOT_W = 5;

    typedef enum logic [ACT_W-1:0] {
        ACT_PREPARE  = 3'd0,
        ACT_PLAY     = 3'd1,
        ACT_STOP     = 3'd2,
        ACT_RELEASE  = 3'd3,
        ACT_STOP_ALL = 3'd4
    } action_t;

    // controller -> datapath
    typedef struct packed {
        logic capture;
        logic commit;
        logic sweep_step;
    } ctrl_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic in_is_lookup;
        logic in_is_sweep;
        logic out_free;
        logic occ_empty;
        logic sweep_last;
    } dp_status_t;

endpackage

`default_nettype wire

[design/ssc_datapath.sv]
// Datapath of the sound slot cache: slot table, compare vectors and output register
`default_nettype none

`include "sound_slot_cache_assert.svh"

module ssc_datapath #(
    parameter int SLOT_COUNT = ssc_pkg::SLOT_COUNT_DEF,
    parameter int SLOT_BASE  = ssc_pkg::SLOT_BASE_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire ssc_pkg::ctrl_cmd_t cmd,
    output ssc_pkg::dp_status_t     status,
    input  wire logic [31:0]        s_tdata,
    input  wire logic [7:0]         s_tuser,
    output logic                    m_tvalid,
    input  wire logic               m_tready,
    output logic [31:0]             m_tdata,
    output logic                    m_tlast
);

    localparam int IW = $clog2(SLOT_COUNT);

    function automatic logic [SLOT_COUNT-1:0] lowest_one(input logic [SLOT_COUNT-1:0] v);
        lowest_one = v & (~v + {{(SLOT_COUNT-1){1'b0}}, 1'b1});
    endfunction

    function automatic logic [IW-1:0] encode(input logic [SLOT_COUNT-1:0] onehot);
        logic [IW-1:0] idx;
        idx = '0;
        for (int i = 0; i < SLOT_COUNT; i++)
        begin
            idx = idx | (onehot[i] ? IW'(i) : {IW{1'b0}});
        end
        encode = idx;
    endfunction

    function automatic logic [ssc_pkg::SLOT_W-1:0] slot_of(input logic [IW-1:0] idx);
        logic [31:0] sum;
        sum = {{(32-IW){1'b0}}, idx} + 32'(SLOT_BASE);
        slot_of = sum[ssc_pkg::SLOT_W-1:0];
    endfunction

    logic [ssc_pkg::NUM_W-1:0]  owner_reg [SLOT_COUNT];
    logic [IW-1:0]              victim_reg;
    logic [IW-1:0]              victim_next;
    ssc_pkg::action_t           act_reg;
    logic [ssc_pkg::NUM_W-1:0]  num_reg;
    logic [ssc_pkg::FADE_W-1:0] fade_reg;
    logic [SLOT_COUNT-1:0]      match_reg;
    logic [SLOT_COUNT-1:0]      occ_reg;
    logic [SLOT_COUNT-1:0]      match_next;
    logic [SLOT_COUNT-1:0]      occ_next;

    logic                       out_valid_reg;
    logic                       out_found_reg;
    logic [ssc_pkg::SLOT_W-1:0] out_slot_reg;
    logic                       out_load_reg;
    logic                       out_play_reg;
    logic                       out_fade_reg;
    logic [ssc_pkg::FADE_W-1:0] out_dur_reg;
    logic                       out_last_reg;

    ssc_pkg::action_t           in_act;
    logic [ssc_pkg::NUM_W-1:0]  in_num;
    logic                       hit;
    logic [IW-1:0]              hit_idx;
    logic [SLOT_COUNT-1:0]      sweep_one;
    logic [IW-1:0]              sweep_idx;
    logic                       is_lookup_act;
    logic                       out_free;

    assign in_act = ssc_pkg::action_t'(s_tuser[ssc_pkg::ACT_W-1:0]);
    assign in_num = s_tdata[ssc_pkg::NUM_W-1:0];

    always_comb
    begin
        for (int i = 0; i < SLOT_COUNT; i++)
        begin
            match_next[i] = (owner_reg[i] == in_num);
            occ_next[i]   = (owner_reg[i] != '0);
        end
    end

    assign hit           = |match_reg;
    assign hit_idx       = encode(lowest_one(match_reg));
    assign sweep_one     = lowest_one(occ_reg);
    assign sweep_idx     = encode(sweep_one);
    assign is_lookup_act = (act_reg == ssc_pkg::ACT_PREPARE) || (act_reg == ssc_pkg::ACT_PLAY);
    assign out_free      = !out_valid_reg || m_tready;
    assign victim_next   = (victim_reg == IW'(SLOT_COUNT - 1)) ? '0 : victim_reg + 1'b1;

    assign status.in_is_lookup = (in_act == ssc_pkg::ACT_PREPARE) || (in_act == ssc_pkg::ACT_PLAY)
                              || (in_act == ssc_pkg::ACT_STOP) || (in_act == ssc_pkg::ACT_RELEASE);
    assign status.in_is_sweep  = (in_act == ssc_pkg::ACT_STOP_ALL);
    assign status.out_free     = out_free;
    assign status.occ_empty    = (occ_reg == '0);
    assign status.sweep_last   = ((occ_reg & ~sweep_one) == '0);

    // item capture; compare against the table happens at the same edge
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            act_reg  <= in_act;
            num_reg  <= in_num;
            fade_reg <= s_tdata[ssc_pkg::NUM_W +: ssc_pkg::FADE_W];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SLOT_COUNT; i++)
            begin
                owner_reg[i] <= '0;
            end
            victim_reg <= '0;
            match_reg  <= '0;
            occ_reg    <= '0;
        end
        else
        begin
            if (cmd.capture)
            begin
                match_reg <= match_next;
                occ_reg   <= occ_next;
            end
            if (cmd.commit)
            begin
                if (is_lookup_act)
                begin
                    if (!hit)
                    begin
                        owner_reg[victim_reg] <= num_reg;
                        victim_reg            <= victim_next;
                    end
                end
                else if (hit)
                begin
                    owner_reg[hit_idx] <= '0;
                end
            end
            if (cmd.sweep_step)
            begin
                owner_reg[sweep_idx] <= '0;
                occ_reg              <= occ_reg & ~sweep_one;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.commit || cmd.sweep_step)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            out_last_reg <= 1'b1;
            if (is_lookup_act)
            begin
                out_found_reg <= 1'b1;
                out_slot_reg  <= slot_of(hit ? hit_idx : victim_reg);
                out_load_reg  <= !hit;
                out_play_reg  <= (act_reg == ssc_pkg::ACT_PLAY);
                out_fade_reg  <= 1'b0;
                out_dur_reg   <= '0;
            end
            else
            begin
                out_found_reg <= hit;
                out_slot_reg  <= hit ? slot_of(hit_idx) : '0;
                out_load_reg  <= 1'b0;
                out_play_reg  <= 1'b0;
                out_fade_reg  <= hit && (act_reg == ssc_pkg::ACT_STOP);
                out_dur_reg   <= (hit && (act_reg == ssc_pkg::ACT_STOP)) ? fade_reg : '0;
            end
        end
        else if (cmd.sweep_step)
        begin
            out_found_reg <= 1'b1;
            out_slot_reg  <= slot_of(sweep_idx);
            out_load_reg  <= 1'b0;
            out_play_reg  <= 1'b0;
            out_fade_reg  <= 1'b1;
            out_dur_reg   <= fade_reg;
            out_last_reg  <= status.sweep_last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {7'b0, out_dur_reg, out_fade_reg, out_play_reg, out_load_reg,
                       out_slot_reg, out_found_reg};

    `SSC_ASSERT(a_victim_range, victim_reg <= IW'(SLOT_COUNT - 1), "victim pointer out of range")
    `SSC_ASSERT_NEVER(a_load_busy, (cmd.commit || cmd.sweep_step) && !out_free, "output overwritten")
    `SSC_ASSERT(a_sweep_clears,
                cmd.sweep_step |=> $countones(occ_reg) + 1 == $countones($past(occ_reg)),
                "sweep did not clear one slot")

endmodule

`default_nettype wire

[design/ssc_ctrl.sv]
// Controller state machine of the sound slot cache
`default_nettype none

module ssc_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    input  wire ssc_pkg::dp_status_t status,
    output ssc_pkg::ctrl_cmd_t       cmd
);

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_COMMIT = 3'b010,
        ST_SWEEP  = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next     = state_reg;
        cmd.capture    = 1'b0;
        cmd.commit     = 1'b0;
        cmd.sweep_step = 1'b0;
        s_tready       = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.capture = 1'b1;
                    // unknown actions are taken and dropped
                    if (status.in_is_lookup)
                        state_next = ST_COMMIT;
                    else if (status.in_is_sweep)
                        state_next = ST_SWEEP;
                end
            end
            ST_COMMIT:
            begin
                if (status.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_SWEEP:
            begin
                if (status.occ_empty)
                    state_next = ST_IDLE;
                else if (status.out_free)
                begin
                    cmd.sweep_step = 1'b1;
                    if (status.sweep_last)
                        state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

`default_nettype wire

[design/sound_slot_cache.sv]
// Sound slot cache: maps sound numbers to playback slots, round-robin replacement
//
// Input channel s_*: one command item per handshake; s_tuser carries the action,
// s_tdata the sound number and fade time. Output channel m_*: result items, with
// m_tlast on the final result of each command.
// Prepare, play, stop and release give one result. The number is compared with all
// slots at the accepting edge into a registered match vector; the table and the output
// register are updated in the commit state once the output register is free.
// Stop-all clears the occupied slots from the lowest slot upward, one result per cycle
// while the output register is free; with no occupied slot it gives no result.
// Unknown actions are accepted and dropped.
// A registered output stage separates the channels: a new command is taken while
// the last result still waits; a stalled receiver holds results in that register
// and pauses the controller before the next result is produced.
// Reset empties every slot and sets the replacement pointer to the first slot at
// once; the block is ready as soon as reset is released.
`default_nettype none

module sound_slot_cache #(
    parameter int SLOT_COUNT = ssc_pkg::SLOT_COUNT_DEF,
    parameter int SLOT_BASE  = ssc_pkg::SLOT_BASE_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // sound_number[15:0], fade_time[31:16]
    input  wire logic [7:0]  s_tuser,   // action[2:0], zero above
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // found[0], slot[5:1], load_request[6],
                                        // play_request[7], fade_request[8],
                                        // fade_duration[24:9], zero above
    output logic             m_tlast    // last
);

    ssc_pkg::ctrl_cmd_t  cmd;
    ssc_pkg::dp_status_t status;

    ssc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    ssc_datapath #(
        .SLOT_COUNT (SLOT_COUNT),
        .SLOT_BASE  (SLOT_BASE)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .status   (status),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

`default_nettype wire

[tb/sv/testbench.sv]
// Self-checking testbench for the sound slot cache: directed and random command streams
`timescale 1ns / 100ps

module testbench;

    localparam int ACT_W  = ssc_pkg::ACT_W;
    localparam int NUM_W  = ssc_pkg::NUM_W;
    localparam int FADE_W = ssc_pkg::FADE_W;
    localparam int SLOT_W = ssc_pkg::SLOT_W;
    localparam int SLOTS  = ssc_pkg::SLOT_COUNT_DEF;
    localparam int BASE   = ssc_pkg::SLOT_BASE_DEF;

    localparam int HALF_PERIOD    = 10;
    localparam int RESET_CYCLES   = 11;
    localparam int RANDOM_ITEMS   = 300;
    localparam int STALL_LIMIT    = 4000;
    localparam int DRAIN_CYCLES   = 40;
    localparam int HOLDOFF_START  = 250;
    localparam int HOLDOFF_CYCLES = 300;
    localparam int CALM_FROM      = 700;
    localparam int CALM_TO        = 900;
    localparam int IDLE_PCT       = 20;
    localparam int MAX_REPORTS    = 10;
    localparam int POOL_SIZE      = 24;

    // highest action code; everything above stop-all is dropped by the block
    localparam logic [ACT_W-1:0] ACT_TOP = '1;

    typedef struct packed {
        logic [ACT_W-1:0]  action;
        logic [NUM_W-1:0]  sound;
        logic [FADE_W-1:0] fade;
    } command_t;

    typedef struct packed {
        logic              found;
        logic [SLOT_W-1:0] slot;
        logic              load;
        logic              play;
        logic              fade;
        logic [FADE_W-1:0] duration;
        logic              last;
    } slot_result_t;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata  = '0;   // sound_number[15:0], fade_time[31:16]
    logic [7:0]  s_tuser  = '0;   // action[2:0], zero above
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;         // found[0], slot[5:1], load[6], play[7], fade[8],
                                  // fade_duration[24:9], zero above
    logic        m_tlast;

    command_t         command_queue[$];
    slot_result_t     expected_results[$];
    logic [NUM_W-1:0] slot_table [SLOTS];
    int               victim_ptr;

    int cycle_no        = 0;
    int cmds_accepted   = 0;
    int stop_all_cmds   = 0;
    int results_checked = 0;
    int loads_seen      = 0;
    int fades_seen      = 0;
    int mismatches      = 0;
    int stall_cycles    = 0;
    int holdoff_left    = 0;
    bit holdoff_done    = 1'b0;
    logic calm;

    sound_slot_cache i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always #HALF_PERIOD clk = ~clk;

    always @(posedge clk)
    begin
        cycle_no <= cycle_no + 1;
    end

    assign calm = (cycle_no >= CALM_FROM) && (cycle_no < CALM_TO);

    function automatic int find_slot(input logic [NUM_W-1:0] sound);
        for (int k = 0; k < SLOTS; k++)
        begin
            if (slot_table[k] == sound)
                return k;
        end
        return -1;
    endfunction

    // Updates the slot table and queues the result items one command causes
    task automatic predict_slot_results(input command_t cmd);
        slot_result_t res;
        int hit;
        int top;
        res = '0;
        top = -1;
        case (cmd.action)
            ssc_pkg::ACT_PREPARE, ssc_pkg::ACT_PLAY:
            begin
                hit = find_slot(cmd.sound);
                if (hit < 0)
                begin
                    hit = victim_ptr;
                    slot_table[hit] = cmd.sound;
                    victim_ptr = (victim_ptr + 1) % SLOTS;
                    res.load = 1'b1;
                end
                res.found = 1'b1;
                res.slot  = SLOT_W'(hit + BASE);
                res.play  = (cmd.action == ssc_pkg::ACT_PLAY);
                res.last  = 1'b1;
                expected_results.push_back(res);
            end
            ssc_pkg::ACT_STOP, ssc_pkg::ACT_RELEASE:
            begin
                hit = find_slot(cmd.sound);
                if (hit >= 0)
                begin
                    slot_table[hit] = '0;
                    res.found = 1'b1;
                    res.slot  = SLOT_W'(hit + BASE);
                    if (cmd.action == ssc_pkg::ACT_STOP)
                    begin
                        res.fade     = 1'b1;
                        res.duration = cmd.fade;
                    end
                end
                res.last = 1'b1;
                expected_results.push_back(res);
            end
            ssc_pkg::ACT_STOP_ALL:
            begin
                stop_all_cmds++;
                for (int k = 0; k < SLOTS; k++)
                begin
                    if (slot_table[k] != '0)
                        top = k;
                end
                for (int k = 0; k < SLOTS; k++)
                begin
                    if (slot_table[k] != '0)
                    begin
                        slot_table[k] = '0;
                        res          = '0;
                        res.found    = 1'b1;
                        res.slot     = SLOT_W'(k + BASE);
                        res.fade     = 1'b1;
                        res.duration = cmd.fade;
                        res.last     = (k == top);
                        expected_results.push_back(res);
                    end
                end
            end
            default:
            begin
            end
        endcase
    endtask

    task automatic add_command(input logic [ACT_W-1:0] action,
                               input logic [NUM_W-1:0] sound,
                               input logic [FADE_W-1:0] fade);
        command_t cmd;
        cmd.action = action;
        cmd.sound  = sound;
        cmd.fade   = fade;
        command_queue.push_back(cmd);
    endtask

    // Driver: offers the front of the command queue, holds it until taken
    always @(posedge clk)
    begin
        bit accepted;
        command_t head;
        if (rst_n)
        begin
            accepted = s_tvalid && s_tready;
            if (accepted)
            begin
                predict_slot_results(command_queue.pop_front());
                cmds_accepted++;
            end
            if (!s_tvalid || accepted)
            begin
                if (command_queue.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT))
                begin
                    head = command_queue[0];
                    s_tvalid <= 1'b1;
                    s_tdata  <= {head.fade, head.sound};
                    s_tuser  <= 8'(head.action);
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Receiver ready, with one long hold-off so the output register and then the input back up
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (holdoff_left > 0)
            begin
                holdoff_left = holdoff_left - 1;
                m_tready <= 1'b0;
            end
            else if (!holdoff_done && cycle_no >= HOLDOFF_START)
            begin
                holdoff_done = 1'b1;
                holdoff_left = HOLDOFF_CYCLES;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    // Monitor: each result item against the oldest expectation
    always @(posedge clk)
    begin
        slot_result_t got;
        slot_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = {m_tdata[0], m_tdata[5:1], m_tdata[6], m_tdata[7], m_tdata[8],
                   m_tdata[24:9], m_tlast};
            results_checked++;
            loads_seen += got.load;
            fades_seen += got.fade;
            if (expected_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("%0t: unexpected result slot=%0d found=%b last=%b",
                             $realtime, got.slot, got.found, got.last);
            end
            else
            begin
                want = expected_results.pop_front();
                if (got !== want)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                    begin
                        $display("%0t: result %0d mismatch", $realtime, results_checked);
                        $display("  expected found=%b slot=%0d load=%b play=%b fade=%b %s",
                                 want.found, want.slot, want.load, want.play, want.fade,
                                 $sformatf("dur=%h last=%b", want.duration, want.last));
                        $display("  actual   found=%b slot=%0d load=%b play=%b fade=%b %s",
                                 got.found, got.slot, got.load, got.play, got.fade,
                                 $sformatf("dur=%h last=%b", got.duration, got.last));
                    end
                end
            end
        end
    end

    // Watchdog on cycles with no item moving on either side
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("Timeout: no item moved for %0d cycles", STALL_LIMIT);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial
    begin
        logic [NUM_W-1:0]  pool [POOL_SIZE];
        logic [ACT_W-1:0]  act;
        logic [NUM_W-1:0]  num;
        logic [FADE_W-1:0] fade;
        int span;
        int burst;
        int roll;
        int counted;

        foreach (slot_table[k])
            slot_table[k] = '0;
        victim_ptr = 0;
        counted    = 0;

        // directed: extremes, hits and misses, number zero on an empty entry,
        // stop-all on an empty table and on a partial one, unknown actions
        add_command(ssc_pkg::ACT_PREPARE,  16'h0001, 16'h0000);
        add_command(ssc_pkg::ACT_PLAY,     16'hFFFF, 16'hFFFF);
        add_command(ssc_pkg::ACT_PLAY,     16'h0001, 16'h0000);
        add_command(ssc_pkg::ACT_PREPARE,  16'hFFFF, 16'h0000);
        add_command(ssc_pkg::ACT_STOP,     16'h0001, 16'hFFFF);
        add_command(ssc_pkg::ACT_STOP,     16'h0001, 16'h1234);
        add_command(ssc_pkg::ACT_RELEASE,  16'hFFFF, 16'hFFFF);
        add_command(ssc_pkg::ACT_RELEASE,  16'h1234, 16'h0000);
        add_command(ssc_pkg::ACT_PREPARE,  16'h0000, 16'h0000);
        add_command(ssc_pkg::ACT_PLAY,     16'h0000, 16'h0000);
        add_command(ssc_pkg::ACT_STOP,     16'h0000, 16'h8000);
        add_command(ssc_pkg::ACT_STOP_ALL, 16'h0000, 16'h5555);
        for (int a = int'(ssc_pkg::ACT_STOP_ALL) + 1; a <= int'(ACT_TOP); a++)
            add_command(ACT_W'(a), 16'hFFFF, 16'hFFFF);
        add_command(ssc_pkg::ACT_PREPARE,  16'h8001, 16'h0000);
        add_command(ssc_pkg::ACT_PLAY,     16'h7FFE, 16'h0000);
        add_command(ssc_pkg::ACT_PREPARE,  16'h0100, 16'h0000);
        add_command(ssc_pkg::ACT_STOP_ALL, 16'hFFFF, 16'hFFFF);
        add_command(ssc_pkg::ACT_STOP_ALL, 16'h0000, 16'h0000);
        add_command(ssc_pkg::ACT_RELEASE,  16'h0000, 16'hFFFF);
        add_command(ssc_pkg::ACT_STOP,     16'hAAAA, 16'h0000);

        // random: bursts over a working set of numbers; small sets hit often,
        // sets wider than the table force round-robin eviction
        while (counted < RANDOM_ITEMS)
        begin
            span = $urandom_range(2, POOL_SIZE);
            for (int k = 0; k < span; k++)
                pool[k] = NUM_W'($urandom_range(1, 16'hFFFF));
            burst = $urandom_range(4, 20);
            repeat (burst)
            begin
                roll = $urandom_range(99);
                num  = pool[$urandom_range(span - 1)];
                fade = FADE_W'($urandom);
                if (roll < 50)
                    act = $urandom_range(1) ? ssc_pkg::ACT_PLAY : ssc_pkg::ACT_PREPARE;
                else if (roll < 85)
                    act = $urandom_range(1) ? ssc_pkg::ACT_STOP : ssc_pkg::ACT_RELEASE;
                else if (roll < 90)
                    act = ssc_pkg::ACT_STOP_ALL;
                else if (roll < 95)
                begin
                    act = ACT_W'($urandom_range(int'(ssc_pkg::ACT_PREPARE),
                                                int'(ssc_pkg::ACT_RELEASE)));
                    num = ($urandom_range(3) == 0) ? '0 : NUM_W'($urandom);
                end
                else
                begin
                    act = ACT_W'($urandom_range(int'(ssc_pkg::ACT_STOP_ALL) + 1,
                                                int'(ACT_TOP)));
                    num = NUM_W'($urandom);
                end
                add_command(act, num, fade);
                if (act <= ssc_pkg::ACT_STOP_ALL)
                    counted++;
            end
            if ($urandom_range(2) == 0)
            begin
                add_command(ssc_pkg::ACT_STOP_ALL, NUM_W'($urandom), FADE_W'($urandom));
                counted++;
            end
        end

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        do
            @(negedge clk);
        while (command_queue.size() != 0 || s_tvalid);
        while (expected_results.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("Ran %0d commands (%0d stop-all) through a %0d-cycle receiver hold-off",
                 cmds_accepted, stop_all_cmds, HOLDOFF_CYCLES);
        $display("Checked %0d results: %0d loads, %0d fades, %0d mismatches",
                 results_checked, loads_seen, fades_seen, mismatches);
        if (mismatches == 0 && expected_results.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
